### rtl/assert_macros.svh
// Assertion macros used by the executor's top level to check it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is asserted.
`define SVM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define SVM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/svm_pkg.sv
// Types and constants shared by the stack machine executor modules.
package svm_pkg;

    localparam logic [4:0] OP_JUMP       = 5'd0;
    localparam logic [4:0] OP_JNZ        = 5'd1;
    localparam logic [4:0] OP_JZ         = 5'd2;
    localparam logic [4:0] OP_LOOKUP     = 5'd3;
    localparam logic [4:0] OP_LOOKUP_NEW = 5'd4;
    localparam logic [4:0] OP_VREAD      = 5'd5;
    localparam logic [4:0] OP_VWRITE     = 5'd6;
    localparam logic [4:0] OP_PUSH       = 5'd7;
    localparam logic [4:0] OP_POP        = 5'd8;
    localparam logic [4:0] OP_ADD        = 5'd9;
    localparam logic [4:0] OP_SUB        = 5'd10;
    localparam logic [4:0] OP_MUL        = 5'd11;
    localparam logic [4:0] OP_DIV        = 5'd12;
    localparam logic [4:0] OP_EQ         = 5'd13;
    localparam logic [4:0] OP_LT         = 5'd14;
    localparam logic [4:0] OP_PRINT      = 5'd15;
    localparam logic [4:0] OP_HALT       = 5'd16;

    localparam logic [2:0] FAULT_NONE      = 3'd0;
    localparam logic [2:0] FAULT_UNDERFLOW = 3'd1;
    localparam logic [2:0] FAULT_OVERFLOW  = 3'd2;
    localparam logic [2:0] FAULT_DIV_ZERO  = 3'd3;
    localparam logic [2:0] FAULT_STORE_FULL = 3'd4;

    localparam logic [15:0] HALT_PC = 16'hffff;
    localparam int DIV_STEPS = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_EXEC
    } svm_state_t;

    typedef struct packed {
        logic accept;
        logic var_rd;
        logic div_start;
        logic commit;
    } svm_cmd_t;

    typedef struct packed {
        logic is_div;
        logic div_done;
        logic out_free;
    } svm_status_t;

endpackage

### rtl/svm_datapath.sv
// Datapath of the executor: stack, variable and binding memories, ALU, divider, output register.
module svm_datapath
    import svm_pkg::*;
#(
    parameter int STACK_DEPTH    = 64,
    parameter int VARIABLE_COUNT = 256,
    parameter int SYMBOL_COUNT   = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  svm_cmd_t    cmd,
    output svm_status_t status,
    input  logic [47:0] s_tdata,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,
    output logic        m_tuser
);

    localparam int SW     = $clog2(STACK_DEPTH);
    localparam int DW     = $clog2(STACK_DEPTH + 1);
    localparam int VW     = $clog2(VARIABLE_COUNT);
    localparam int VCW    = $clog2(VARIABLE_COUNT + 1);
    localparam int BIND_N = (SYMBOL_COUNT < 256) ? SYMBOL_COUNT : 256;
    localparam int BW     = $clog2(BIND_N);

    logic [31:0]   stack_mem [STACK_DEPTH];
    logic [31:0]   var_mem [VARIABLE_COUNT];
    logic [VW-1:0] bind_mem [BIND_N];
    logic [BW-1:0] sym_tbl [256];

    logic [15:0]        pc_reg, pc_next, plen_reg;
    logic               halt_reg, halt_next;
    logic [DW-1:0]      depth_reg, depth_next;
    logic [VCW-1:0]     vcount_reg, vcount_next;
    logic [BIND_N-1:0]  bvalid_reg, bvalid_next;
    logic [4:0]         func_reg;
    logic [31:0]        arg_reg, top_reg, sec_reg, var_reg, prod_reg;
    logic [BW-1:0]      sym_reg;
    logic [VW-1:0]      bidx_reg;
    logic               m_valid_reg;
    logic [55:0]        m_data_reg;
    logic               m_user_reg;

    logic [31:0] rem_reg, quo_reg, dvs_reg;
    logic        qneg_reg, div_busy_reg;
    logic [5:0]  div_cnt_reg;

    logic [DW-1:0] depth_m1, depth_m2;
    logic [VW-1:0] bound_idx, var_raddr;
    logic          bound;
    logic [32:0]   rem_sh, diff;
    logic [31:0]   a_mag, b_mag, quotient;

    logic          stk_we, var_we, bind_we;
    logic [SW-1:0] stk_waddr;
    logic [31:0]   stk_wdata, var_wdata, pval, alu_r;
    logic [VW-1:0] var_waddr, bind_wdata;
    logic [15:0]   next_pc;
    logic [2:0]    fault;
    logic          pvalid, halted_out, pre_halt, top_ok, bidx_ok;

    for (genvar g = 0; g < 256; g++) begin : g_sym
        assign sym_tbl[g] = BW'(g % BIND_N);
    end

    assign depth_m1  = depth_reg - DW'(1);
    assign depth_m2  = depth_reg - DW'(2);
    assign bound     = bvalid_reg[sym_reg];
    assign bound_idx = bound ? bidx_reg : '0;
    assign var_raddr = (func_reg == OP_PRINT) ? bound_idx : top_reg[VW-1:0];
    assign top_ok    = top_reg < 32'(vcount_reg);
    assign bidx_ok   = VCW'(bound_idx) < vcount_reg;
    assign pre_halt  = halt_reg || (pc_reg >= plen_reg);

    assign a_mag    = sec_reg[31] ? (32'd0 - sec_reg) : sec_reg;
    assign b_mag    = top_reg[31] ? (32'd0 - top_reg) : top_reg;
    assign rem_sh   = {rem_reg, quo_reg[31]};
    assign diff     = rem_sh - {1'b0, dvs_reg};
    assign quotient = qneg_reg ? (32'd0 - quo_reg) : quo_reg;

    assign status.is_div   = (func_reg == OP_DIV);
    assign status.div_done = !div_busy_reg;
    assign status.out_free = !m_valid_reg || m_tready;

    always_comb begin
        pc_next     = pc_reg + 16'd1;
        halt_next   = halt_reg;
        depth_next  = depth_reg;
        vcount_next = vcount_reg;
        bvalid_next = bvalid_reg;
        fault       = FAULT_NONE;
        pvalid      = 1'b0;
        pval        = '0;
        stk_we      = 1'b0;
        stk_waddr   = depth_reg[SW-1:0];
        stk_wdata   = '0;
        var_we      = 1'b0;
        var_waddr   = top_reg[VW-1:0];
        var_wdata   = sec_reg;
        bind_we     = 1'b0;
        bind_wdata  = '0;
        alu_r       = '0;
        case (func_reg)
            OP_ADD:  alu_r = sec_reg + top_reg;
            OP_SUB:  alu_r = sec_reg - top_reg;
            OP_MUL:  alu_r = prod_reg;
            OP_DIV:  alu_r = quotient;
            OP_EQ:   alu_r = {31'd0, sec_reg == top_reg};
            OP_LT:   alu_r = {31'd0, $signed(sec_reg) < $signed(top_reg)};
            default: alu_r = '0;
        endcase
        if (func_reg inside {OP_JNZ, OP_JZ, OP_VREAD, OP_POP} && depth_reg < DW'(1)) begin
            fault = FAULT_UNDERFLOW;
        end else if (func_reg inside {OP_VWRITE, [OP_ADD:OP_LT]} && depth_reg < DW'(2)) begin
            fault = FAULT_UNDERFLOW;
        end else if (func_reg inside {OP_LOOKUP, OP_LOOKUP_NEW, OP_PUSH}
                     && depth_reg == DW'(STACK_DEPTH)) begin
            fault = FAULT_OVERFLOW;
        end else if (func_reg == OP_LOOKUP_NEW && !bound
                     && vcount_reg == VCW'(VARIABLE_COUNT)) begin
            fault = FAULT_STORE_FULL;
        end else if (func_reg == OP_DIV && top_reg == '0) begin
            fault = FAULT_DIV_ZERO;
        end
        case (func_reg)
            OP_JUMP: pc_next = arg_reg[15:0];
            OP_JNZ, OP_JZ: begin
                depth_next = depth_m1;
                if ((func_reg == OP_JNZ) == (top_reg != '0)) begin
                    pc_next = arg_reg[15:0];
                end
            end
            OP_LOOKUP, OP_PRINT: begin
                if (!bound) begin
                    bvalid_next[sym_reg] = 1'b1;
                    bind_we = 1'b1;
                end
                if (func_reg == OP_LOOKUP) begin
                    stk_we     = 1'b1;
                    stk_wdata  = 32'(bound_idx);
                    depth_next = depth_reg + DW'(1);
                end else begin
                    pvalid = 1'b1;
                    pval   = bidx_ok ? var_reg : '0;
                end
            end
            OP_LOOKUP_NEW: begin
                stk_we     = 1'b1;
                depth_next = depth_reg + DW'(1);
                if (bound) begin
                    stk_wdata = 32'(bidx_reg);
                end else begin
                    stk_wdata            = 32'(vcount_reg);
                    bvalid_next[sym_reg] = 1'b1;
                    bind_we              = 1'b1;
                    bind_wdata           = vcount_reg[VW-1:0];
                    var_we               = 1'b1;
                    var_waddr            = vcount_reg[VW-1:0];
                    var_wdata            = '0;
                    vcount_next          = vcount_reg + VCW'(1);
                end
            end
            OP_VREAD: begin
                stk_we    = 1'b1;
                stk_waddr = depth_m1[SW-1:0];
                stk_wdata = top_ok ? var_reg : '0;
            end
            OP_VWRITE: begin
                depth_next = depth_m2;
                var_we     = top_ok;
            end
            OP_PUSH: begin
                stk_we     = 1'b1;
                stk_wdata  = arg_reg;
                depth_next = depth_reg + DW'(1);
            end
            OP_POP: depth_next = depth_m1;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_LT: begin
                stk_we     = 1'b1;
                stk_waddr  = depth_m2[SW-1:0];
                stk_wdata  = alu_r;
                depth_next = depth_m1;
            end
            OP_HALT: begin
                pc_next   = HALT_PC;
                halt_next = 1'b1;
            end
            default: ;
        endcase
        if (pre_halt || fault != FAULT_NONE) begin
            pc_next     = pc_reg;
            halt_next   = halt_reg;
            depth_next  = depth_reg;
            vcount_next = vcount_reg;
            bvalid_next = bvalid_reg;
            stk_we      = 1'b0;
            var_we      = 1'b0;
            bind_we     = 1'b0;
            pvalid      = 1'b0;
            pval        = '0;
        end
        next_pc    = pc_next;
        halted_out = pre_halt
                     || (fault == FAULT_NONE && (halt_next || pc_next >= plen_reg));
        if (pre_halt) begin
            fault = FAULT_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            func_reg <= s_tdata[4:0];
            arg_reg  <= s_tdata[36:5];
            sym_reg  <= sym_tbl[s_tdata[44:37]];
            top_reg  <= stack_mem[depth_m1[SW-1:0]];
            sec_reg  <= stack_mem[depth_m2[SW-1:0]];
            bidx_reg <= bind_mem[sym_tbl[s_tdata[44:37]]];
        end
        if (cmd.var_rd) begin
            var_reg  <= var_mem[var_raddr];
            prod_reg <= sec_reg * top_reg;
        end
        if (cmd.commit && stk_we) begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        if (cmd.commit && var_we) begin
            var_mem[var_waddr] <= var_wdata;
        end
        if (cmd.commit && bind_we) begin
            bind_mem[sym_reg] <= bind_wdata;
        end
        if (cmd.commit) begin
            m_data_reg <= {4'd0, fault, halted_out, pval, next_pc};
            m_user_reg <= pvalid;
        end
        if (cmd.div_start) begin
            rem_reg  <= '0;
            quo_reg  <= a_mag;
            dvs_reg  <= b_mag;
            qneg_reg <= sec_reg[31] ^ top_reg[31];
        end else if (div_busy_reg) begin
            if (!diff[32]) begin
                rem_reg <= diff[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[31:0];
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= '0;
            plen_reg     <= 16'd1;
            halt_reg     <= 1'b0;
            depth_reg    <= '0;
            vcount_reg   <= '0;
            bvalid_reg   <= '0;
            m_valid_reg  <= 1'b0;
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                plen_reg <= cfg_wr_data;
            end
            if (cmd.commit) begin
                pc_reg     <= pc_next;
                halt_reg   <= halt_next;
                depth_reg  <= depth_next;
                vcount_reg <= vcount_next;
                bvalid_reg <= bvalid_next;
            end
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.div_start) begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= 6'(DIV_STEPS);
            end else if (div_busy_reg) begin
                div_cnt_reg <= div_cnt_reg - 6'd1;
                if (div_cnt_reg == 6'd1) begin
                    div_busy_reg <= 1'b0;
                end
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

### rtl/svm_ctrl.sv
// Controller state machine that sequences each instruction through the datapath.
module svm_ctrl
    import svm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  svm_status_t status,
    output svm_cmd_t    cmd
);

    svm_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.var_rd = 1'b1;
                if (status.is_div) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    state_next = ST_EXEC;
                end
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

### rtl/stack_vm_instruction_executor.sv
// Top level of the stack machine instruction executor.
// Each request on the slave channel is one instruction; each one yields exactly one
// request on the master channel with the next program counter, any printed value,
// the halted flag and a fault code. A fault leaves all machine state unchanged.
// An instruction goes through these steps from acceptance to its result being
// loaded into the output register: accept with the stack and binding reads, the
// variable store read, then execute and write back. Divide waits for the
// one-bit-per-cycle restoring divider. The next instruction is taken as soon as the
// controller is idle, even while the previous result still waits in the output
// register; if the receiver stalls, execution of the following instruction holds in
// its last step until the output register is free.
// The user must write the program length register via cfg_wr_en and cfg_wr_data
// only while the block is idle; it does not enforce this. Reset clears the counter,
// stack depth, variable count, halt flag and symbol bindings; length resets to one.
`include "assert_macros.svh"
module stack_vm_instruction_executor
    import svm_pkg::*;
#(
    parameter int STACK_DEPTH    = 64,
    parameter int VARIABLE_COUNT = 256,
    parameter int SYMBOL_COUNT   = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // func[4:0], argument[36:5], symbol[44:37], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // next_pc[15:0], print_value[47:16], halted[48],
                                   // fault[51:49], zero fill
    output logic        m_tuser,   // print_valid
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    svm_cmd_t    cmd;
    svm_status_t status;

    svm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    svm_datapath #(
        .STACK_DEPTH    (STACK_DEPTH),
        .VARIABLE_COUNT (VARIABLE_COUNT),
        .SYMBOL_COUNT   (SYMBOL_COUNT)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    `SVM_ASSERT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "accepted a request while busy")
    `SVM_ASSERT(a_commit_needs_room, aclk, aresetn, cmd.commit |-> status.out_free, "result written over a waiting request")
    `SVM_ASSERT(a_print_no_fault, aclk, aresetn, m_tvalid && m_tuser |-> m_tdata[51:49] == FAULT_NONE, "print reported with a fault")
    `SVM_ASSERT(a_halt_no_fault, aclk, aresetn, m_tvalid && m_tdata[48] |-> m_tdata[51:49] == FAULT_NONE, "halted reported with a fault")

endmodule

### bench/tb_stack_vm_instruction_executor.sv
// Self-checking testbench for the stack machine instruction executor.
module tb_stack_vm_instruction_executor
    import svm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] next_pc;
        logic        print_valid;
        logic [31:0] print_value;
        logic        halted;
        logic [2:0]  fault;
    } outcome_t;

    class exec_scoreboard;
        logic [15:0] prog_len;
        logic [15:0] pc;
        logic [31:0] stack [64];
        int          depth;
        logic [31:0] vars [256];
        int          var_count;
        logic [7:0]  bind_idx [256];
        bit          bind_ok [256];
        bit          halt_seen;
        outcome_t    pending [$];
        int          errors;

        function void clear();
            prog_len = 16'd1;
            pc = 16'd0;
            depth = 0;
            var_count = 0;
            halt_seen = 0;
            errors = 0;
            foreach (bind_ok[i]) bind_ok[i] = 0;
        endfunction

        function logic [31:0] var_value(logic [31:0] idx);
            if (idx < var_count) return vars[idx];
            return 32'd0;
        endfunction

        function void note_instruction(logic [4:0] op, logic [31:0] arg, logic [7:0] sym);
            outcome_t    o;
            logic [15:0] nxt;
            logic [31:0] a, b, r;
            logic [2:0]  flt;
            o = '{pc, 1'b0, 32'd0, 1'b1, FAULT_NONE};
            if (halt_seen || pc >= prog_len) begin
                pending = {pending, o};
                return;
            end
            nxt = pc + 16'd1;
            flt = FAULT_NONE;
            case (op)
                OP_JUMP: nxt = arg[15:0];
                OP_JNZ, OP_JZ: begin
                    if (depth < 1) flt = FAULT_UNDERFLOW;
                    else begin
                        depth--;
                        if ((op == OP_JNZ) == (stack[depth] != 0)) nxt = arg[15:0];
                    end
                end
                OP_LOOKUP: begin
                    if (depth >= 64) flt = FAULT_OVERFLOW;
                    else begin
                        if (!bind_ok[sym]) begin
                            bind_ok[sym] = 1;
                            bind_idx[sym] = 8'd0;
                        end
                        stack[depth++] = 32'(bind_idx[sym]);
                    end
                end
                OP_LOOKUP_NEW: begin
                    if (depth >= 64) flt = FAULT_OVERFLOW;
                    else if (!bind_ok[sym] && var_count >= 256) flt = FAULT_STORE_FULL;
                    else begin
                        if (!bind_ok[sym]) begin
                            vars[var_count] = 32'd0;
                            bind_idx[sym] = var_count[7:0];
                            bind_ok[sym] = 1;
                            var_count++;
                        end
                        stack[depth++] = 32'(bind_idx[sym]);
                    end
                end
                OP_VREAD: begin
                    if (depth < 1) flt = FAULT_UNDERFLOW;
                    else stack[depth-1] = var_value(stack[depth-1]);
                end
                OP_VWRITE: begin
                    if (depth < 2) flt = FAULT_UNDERFLOW;
                    else begin
                        if (stack[depth-1] < var_count) vars[stack[depth-1]] = stack[depth-2];
                        depth -= 2;
                    end
                end
                OP_PUSH: begin
                    if (depth >= 64) flt = FAULT_OVERFLOW;
                    else stack[depth++] = arg;
                end
                OP_POP: begin
                    if (depth < 1) flt = FAULT_UNDERFLOW;
                    else depth--;
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_LT: begin
                    if (depth < 2) flt = FAULT_UNDERFLOW;
                    else begin
                        b = stack[depth-1];
                        a = stack[depth-2];
                        if (op == OP_DIV && b == 0) flt = FAULT_DIV_ZERO;
                        else begin
                            case (op)
                                OP_ADD: r = a + b;
                                OP_SUB: r = a - b;
                                OP_MUL: r = a * b;
                                OP_DIV: begin
                                    if (a == 32'h8000_0000 && b == 32'hffff_ffff) r = a;
                                    else r = $signed(a) / $signed(b);
                                end
                                OP_EQ:  r = (a == b) ? 32'd1 : 32'd0;
                                default: r = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                            endcase
                            depth -= 2;
                            stack[depth++] = r;
                        end
                    end
                end
                OP_PRINT: begin
                    if (!bind_ok[sym]) begin
                        bind_ok[sym] = 1;
                        bind_idx[sym] = 8'd0;
                    end
                    o.print_valid = 1'b1;
                    o.print_value = var_value(32'(bind_idx[sym]));
                end
                OP_HALT: begin
                    nxt = HALT_PC;
                    halt_seen = 1;
                end
                default: ;
            endcase
            if (flt != FAULT_NONE) nxt = pc;
            pc = nxt;
            o.next_pc = nxt;
            o.fault = flt;
            o.halted = (flt == FAULT_NONE) && (halt_seen || nxt >= prog_len);
            pending = {pending, o};
        endfunction

        function void check_result(logic [55:0] data, logic pvalid);
            outcome_t e;
            if (pending.size() == 0) begin
                $error("Result arrived with no request outstanding: %h", data);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data[15:0] !== e.next_pc) begin
                $error("next_pc: expected %0d, got %0d", e.next_pc, data[15:0]);
                errors++;
            end
            if (pvalid !== e.print_valid) begin
                $error("print_valid: expected %0d, got %0d", e.print_valid, pvalid);
                errors++;
            end
            if (data[47:16] !== e.print_value) begin
                $error("print_value: expected %h, got %h", e.print_value, data[47:16]);
                errors++;
            end
            if (data[48] !== e.halted) begin
                $error("halted: expected %0d, got %0d", e.halted, data[48]);
                errors++;
            end
            if (data[51:49] !== e.fault) begin
                $error("fault: expected %0d, got %0d", e.fault, data[51:49]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        m_tuser;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    exec_scoreboard sb;
    bit calm;
    bit hold_request;
    int idle_cycles;

    stack_vm_instruction_executor dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 3000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic issue(logic [4:0] op, logic [31:0] arg, logic [7:0] sym);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 15);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, sym, arg, op};
        do @(posedge aclk); while (!s_tready);
        sb.note_instruction(op, arg, sym);
    endtask

    task automatic set_length(logic [15:0] len);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (45) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= len;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.prog_len = len;
    endtask

    task automatic random_instruction();
        int r;
        logic [31:0] arg;
        r = $urandom_range(0, 99);
        arg = $urandom;
        if (r < 16) begin
            if ($urandom_range(0, 1)) arg = $urandom_range(0, sb.var_count);
            issue(OP_PUSH, arg, 8'($urandom));
        end else if (r < 23) issue(OP_LOOKUP_NEW, arg, 8'($urandom));
        else if (r < 28) issue(OP_LOOKUP, arg, 8'($urandom));
        else if (r < 35) issue(OP_VREAD, arg, 8'($urandom));
        else if (r < 42) issue(OP_VWRITE, arg, 8'($urandom));
        else if (r < 46) issue(OP_POP, arg, 8'($urandom));
        else if (r < 76) issue(5'($urandom_range(OP_ADD, OP_LT)), arg, 8'($urandom));
        else if (r < 83) issue(OP_PRINT, arg, 8'($urandom));
        else if (r < 96) begin
            arg[15:0] = 16'($urandom_range(0, 2000));
            issue(5'($urandom_range(OP_JUMP, OP_JZ)), arg, 8'($urandom));
        end else issue(5'($urandom_range(17, 31)), arg, 8'($urandom));
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        idle_cycles = 0;
        calm = 0;
        hold_request = 0;
        sb = new();
        sb.clear();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        issue(OP_PUSH, 32'd5, 8'd0);
        issue(OP_PUSH, 32'd7, 8'd0);
        set_length(16'hffff);
        issue(OP_POP, 32'd0, 8'd0);
        issue(OP_POP, 32'd0, 8'd0);
        issue(OP_PUSH, 32'h7fff_ffff, 8'd0);
        issue(OP_PUSH, 32'h8000_0000, 8'd0);
        issue(OP_LT, 32'd0, 8'd0);
        issue(OP_PUSH, 32'h8000_0000, 8'd0);
        issue(OP_PUSH, 32'hffff_ffff, 8'd0);
        issue(OP_DIV, 32'd0, 8'd0);
        issue(OP_PUSH, 32'd0, 8'd0);
        issue(OP_DIV, 32'd0, 8'd0);
        issue(OP_PUSH, 32'hffff_fff9, 8'd0);
        issue(OP_DIV, 32'd0, 8'd0);
        issue(OP_LOOKUP_NEW, 32'd0, 8'd255);
        issue(OP_LOOKUP, 32'd0, 8'd7);
        issue(OP_VWRITE, 32'd0, 8'd0);
        issue(OP_PRINT, 32'd0, 8'd255);
        issue(OP_PRINT, 32'd0, 8'd200);
        issue(OP_JZ, 32'hffff_0004, 8'd0);
        issue(OP_JNZ, 32'h0001_0030, 8'd0);
        issue(OP_JUMP, 32'h8000_0010, 8'd0);
        issue(5'd31, 32'd0, 8'd0);
        issue(OP_SUB, 32'd0, 8'd0);
        issue(OP_MUL, 32'd0, 8'd0);

        for (int chunk = 0; chunk < 6; chunk++) begin
            calm = (chunk == 2);
            if (chunk == 1) hold_request = 1;
            if (chunk == 3) set_length(sb.pc + 16'd12);
            if (chunk == 4) set_length(16'hffff);
            if (chunk == 5) begin
                for (int k = 0; k < 68; k++) issue(OP_PUSH, $urandom, 8'($urandom));
                for (int k = 0; k < 40; k++) issue(OP_ADD, 32'd0, 8'd0);
            end
            for (int k = 0; k < 130; k++) random_instruction();
        end
        issue(OP_HALT, 32'd0, 8'd0);
        issue(OP_PUSH, 32'd1, 8'd0);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (sb.errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

    initial begin
        int gap;
        forever begin
            @(negedge aclk);
            if (hold_request && aresetn) begin
                m_tready <= 1'b0;
                repeat (300) @(negedge aclk);
                hold_request = 0;
            end else begin
                gap = calm ? 0 : $urandom_range(0, 15);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata, m_tuser);
        end
    end
endmodule
